// ===== design/rtr565_pkg.sv =====
// Package for the RGBA8 to tiled RGB565/A4 converter.
// Sizes, register indexes and the word types of both channels; no dependencies.
package rtr565_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 2048;
    localparam int ICON_SIZE   = 64;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ICON_COLS   = MAX_WIDTH / ICON_SIZE;
    localparam int ICON_ROWS   = MAX_HEIGHT / ICON_SIZE;
    localparam int ICW_W       = $clog2(ICON_COLS + 1);
    localparam int ICH_W       = $clog2(ICON_ROWS + 1);
    localparam int ICON_W      = $clog2(ICON_COLS * ICON_ROWS);
    localparam int ICON_PIX_W  = $clog2(ICON_SIZE);

    localparam int FULL_INDEX_W = 23;
    localparam int HALF_INDEX_W = 21;
    localparam int LANE_W       = 9;
    localparam int LANES_W      = 4 * LANE_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_COLOR_ON = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_ALPHA_ON = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_ON       = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] g;
        logic [LANE_W-1:0] r;
    } lanes_t;

    typedef struct packed {
        logic [FULL_INDEX_W-1:0] full_index;
        logic [15:0]             full_color;
        logic [3:0]              full_alpha;
        logic                    full_color_write;
        logic                    full_alpha_write;
        logic                    half_write;
        logic [HALF_INDEX_W-1:0] half_index;
        logic [15:0]             half_color;
        logic [3:0]              half_alpha;
        logic                    frame_end;
    } result_t;

endpackage

// ===== design/rtr565_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtr565_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/rtr565_addr.sv =====
// Tiled write addresses: icon number plus 8x8 Morton tile offsets, full and half size.
// Depends on rtr565_pkg.
module rtr565_addr
    import rtr565_pkg::*;
(
    input  logic [COL_W-1:0]        x,
    input  logic [ROW_W-1:0]        y,
    input  logic [ICH_W-1:0]        icons_h,
    output logic [FULL_INDEX_W-1:0] full_index,
    output logic [HALF_INDEX_W-1:0] half_index
);

    localparam int XI_W = COL_W - ICON_PIX_W;
    localparam int PROD_W = ICH_W + XI_W;

    logic [PROD_W-1:0] icon_col_base;
    logic [ICON_W-1:0] icon;
    logic [5:0]        full_morton;
    logic [5:0]        half_morton;

    assign icon_col_base = PROD_W'(icons_h) * PROD_W'(x[COL_W-1:ICON_PIX_W]);
    assign icon = ICON_W'(icon_col_base) + ICON_W'(y[ROW_W-1:ICON_PIX_W]);

    assign full_morton = {y[2], x[2], y[1], x[1], y[0], x[0]};
    assign half_morton = {y[3], x[3], y[2], x[2], y[1], x[1]};

    assign full_index = FULL_INDEX_W'({icon, y[5:3], x[5:3], full_morton});
    assign half_index = HALF_INDEX_W'({icon, y[5:4], x[5:4], half_morton});

endmodule

// ===== design/rgba8_to_tiled_rgb565_a4.sv =====
// Top level: RGBA8 raster pixels to tiled RGB565 + A4 writes with 2x2 downsampling.
// Depends on rtr565_pkg, rtr565_addr and rtr565_ram (line buffer of pair sums).
//
//  channel  | handshake                  | word
//  ---------+----------------------------+----------------------------------
//  pixel    | pixel_valid / pixel_stall  | pixel_t  (red, green, blue, alpha)
//  result   | result_valid / result_stall| result_t (full, half and frame_end)
//  config   | cfg_write                  | cfg_index, cfg_data
//
// One pixel per cycle while pixel_stall is low; a result word is registered in
// out_reg, or in skid_reg while stalled. The line buffer read for an odd row is
// issued with the even-column pixel, so the odd-column pixel finds the upper pair
// sum waiting. The two-word skid takes one pixel during result_stall, then raises
// pixel_stall, a register. Reset clears counters and valid flags, not the line buffer.
module rgba8_to_tiled_rgb565_a4
    import rtr565_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  pixel_t                 pixel,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    function automatic logic [6:0] icons_clamp(logic [6:0] n, logic [6:0] cap);
        logic [6:0] v;
        v = n;
        if (v == 7'd0)
        begin
            v = 7'd1;
        end
        if (v > cap)
        begin
            v = cap;
        end
        return v;
    endfunction

    logic [ICW_W-1:0] icons_w_reg;
    logic [ICH_W-1:0] icons_h_reg;
    logic             full_color_on_reg;
    logic             full_alpha_on_reg;
    logic             half_on_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    lanes_t           pair_reg, pair_next;

    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    accept;
    logic    take;
    logic    col_last, row_last, restart;
    lanes_t  sum, top;
    logic [LANE_W:0] sr, sg, sb, sa;
    logic    half_hit;
    logic [FULL_INDEX_W-1:0] full_index;
    logic [HALF_INDEX_W-1:0] half_index;
    logic    store_wr, store_rd;
    result_t res;

    assign accept = pixel_valid && !skid_valid_reg;
    assign take   = out_valid_reg && !result_stall;
    assign pixel_stall  = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign restart = cfg_write &&
        (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    assign col_last = (col_reg[ICON_PIX_W-1:0] == {ICON_PIX_W{1'b1}}) &&
        (ICW_W'(col_reg[COL_W-1:ICON_PIX_W]) >= icons_w_reg - ICW_W'(1));
    assign row_last = (row_reg[ICON_PIX_W-1:0] == {ICON_PIX_W{1'b1}}) &&
        (ICH_W'(row_reg[ROW_W-1:ICON_PIX_W]) >= icons_h_reg - ICH_W'(1));

    // horizontal pair sums
    assign sum.r = pair_reg.r + LANE_W'(pixel.red);
    assign sum.g = pair_reg.g + LANE_W'(pixel.green);
    assign sum.b = pair_reg.b + LANE_W'(pixel.blue);
    assign sum.a = pair_reg.a + LANE_W'(pixel.alpha);

    assign store_wr = accept && col_reg[0] && !row_reg[0];
    assign store_rd = accept && !col_reg[0] && row_reg[0];

    rtr565_ram #(
        .WIDTH (LANES_W),
        .DEPTH (STORE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (col_reg[COL_W-1:1]),
        .wr_data (sum),
        .rd_en   (store_rd),
        .rd_addr (col_reg[COL_W-1:1]),
        .rd_data (top)
    );

    rtr565_addr u_addr (
        .x          (col_reg),
        .y          (row_reg),
        .icons_h    (icons_h_reg),
        .full_index (full_index),
        .half_index (half_index)
    );

    assign sr = {1'b0, top.r} + {1'b0, sum.r};
    assign sg = {1'b0, top.g} + {1'b0, sum.g};
    assign sb = {1'b0, top.b} + {1'b0, sum.b};
    assign sa = {1'b0, top.a} + {1'b0, sum.a};

    assign half_hit = half_on_reg && col_reg[0] && row_reg[0];

    always_comb
    begin
        res.full_index       = full_index;
        res.full_color       = {pixel.red[7:3], pixel.green[7:2], pixel.blue[7:3]};
        res.full_alpha       = pixel.alpha[7:4];
        res.full_color_write = full_color_on_reg;
        res.full_alpha_write = full_alpha_on_reg;
        res.half_write       = half_hit;
        res.half_index       = half_hit ? half_index : '0;
        res.half_color       = half_hit ? {sr[9:5], sg[9:4], sb[9:5]} : '0;
        res.half_alpha       = half_hit ? sa[9:6] : '0;
        res.frame_end        = col_last && row_last;
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pair_next = pair_reg;
        priority if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            pair_next = '0;
        end
        else if (accept)
        begin
            if (!col_reg[0])
            begin
                pair_next.r = LANE_W'(pixel.red);
                pair_next.g = LANE_W'(pixel.green);
                pair_next.b = LANE_W'(pixel.blue);
                pair_next.a = LANE_W'(pixel.alpha);
            end
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        else
        begin
            // idle: counters and pair sums hold
            col_next  = col_reg;
            row_next  = row_reg;
            pair_next = pair_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icons_w_reg       <= ICW_W'(1);
            icons_h_reg       <= ICH_W'(1);
            full_color_on_reg <= 1'b1;
            full_alpha_on_reg <= 1'b1;
            half_on_reg       <= 1'b1;
            col_reg           <= '0;
            row_reg           <= '0;
            pair_reg          <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pair_reg <= pair_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:
                        icons_w_reg <= ICW_W'(icons_clamp(
                            cfg_data[CFG_DATA_W-1:ICON_PIX_W], 7'(ICON_COLS)));
                    REG_IMAGE_HEIGHT:
                        icons_h_reg <= ICH_W'(icons_clamp(
                            {1'b0, cfg_data[CFG_DATA_W-2:ICON_PIX_W]}, 7'(ICON_ROWS)));
                    REG_FULL_COLOR_ON: full_color_on_reg <= cfg_data[0];
                    REG_FULL_ALPHA_ON: full_alpha_on_reg <= cfg_data[0];
                    REG_HALF_ON:       half_on_reg       <= cfg_data[0];
                    default:           ;
                endcase
            end
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg && !take)
                begin
                    skid_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

endmodule

// ===== dv/rgb565_tile_checker.sv =====
// Checker for rgba8_to_tiled_rgb565_a4: mirrors the register port, predicts each
// result word from the accepted pixel words and compares it field by field.
// Depends on rtr565_pkg.
module rgb565_tile_checker
    import rtr565_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    input  logic                   pixel_stall,
    input  pixel_t                 pixel,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  result_t                result,
    output int                     mismatches,
    output int                     waiting
);

    logic [12:0] width_reg;
    logic [11:0] height_reg;
    logic        color_on;
    logic        alpha_on;
    logic        half_on;
    int unsigned column;
    int unsigned row;
    lanes_t      pair;
    lanes_t      upper_pairs [STORE_DEPTH];
    result_t     expected_words [$];

    function automatic int unsigned icons_across(input int unsigned size,
                                                 input int unsigned max_pixels);
        int unsigned n;
        n = size >> 6;
        if (n == 0)
            n = 1;
        if (n > max_pixels / ICON_SIZE)
            n = max_pixels / ICON_SIZE;
        return n;
    endfunction

    function automatic int unsigned interleave3(input int unsigned x, input int unsigned y);
        int unsigned m;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            m |= ((x >> i) & 1) << (2 * i);
            m |= ((y >> i) & 1) << (2 * i + 1);
        end
        return m;
    endfunction

    function automatic result_t convert_pixel(input pixel_t p);
        result_t     w;
        int unsigned icons_h, w_px, h_px, x, y, icon, hx, hy, slot, fi, hi;
        lanes_t      sum;
        lanes_t      top;
        logic [9:0]  sr, sg, sb, sa;
        icons_h = icons_across(32'(width_reg) * 0 + 32'(height_reg), MAX_HEIGHT);
        w_px = icons_across(32'(width_reg), MAX_WIDTH) * ICON_SIZE;
        h_px = icons_h * ICON_SIZE;
        x = column;
        y = row;
        icon = icons_h * (x >> 6) + (y >> 6);
        w = '0;
        fi = icon * 4096 + (((y >> 3) & 7) << 9) + (((x >> 3) & 7) << 6) + interleave3(x, y);
        w.full_index = fi[FULL_INDEX_W-1:0];
        w.full_color = {p.red[7:3], p.green[7:2], p.blue[7:3]};
        w.full_alpha = p.alpha[7:4];
        w.full_color_write = color_on;
        w.full_alpha_write = alpha_on;
        if ((x & 1) == 0)
        begin
            pair.r = {1'b0, p.red};
            pair.g = {1'b0, p.green};
            pair.b = {1'b0, p.blue};
            pair.a = {1'b0, p.alpha};
        end
        else
        begin
            sum.r = pair.r + {1'b0, p.red};
            sum.g = pair.g + {1'b0, p.green};
            sum.b = pair.b + {1'b0, p.blue};
            sum.a = pair.a + {1'b0, p.alpha};
            slot = (x >> 1) & (STORE_DEPTH - 1);
            if ((y & 1) == 0)
                upper_pairs[slot] = sum;
            else if (half_on)
            begin
                top = upper_pairs[slot];
                sr = {1'b0, top.r} + {1'b0, sum.r};
                sg = {1'b0, top.g} + {1'b0, sum.g};
                sb = {1'b0, top.b} + {1'b0, sum.b};
                sa = {1'b0, top.a} + {1'b0, sum.a};
                hx = x >> 1;
                hy = y >> 1;
                hi = icon * 1024 + (((hy >> 3) & 3) << 8) + (((hx >> 3) & 3) << 6)
                   + interleave3(hx, hy);
                w.half_write = 1'b1;
                w.half_index = hi[HALF_INDEX_W-1:0];
                w.half_color = {sr[9:5], sg[9:4], sb[9:5]};
                w.half_alpha = sa[9:6];
            end
        end
        w.frame_end = (x + 1 >= w_px) && (y + 1 >= h_px);
        if (x + 1 >= w_px)
        begin
            column = 0;
            row = (y + 1 >= h_px) ? 0 : y + 1;
        end
        else
            column = x + 1;
        return w;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("fidx=%h fcol=%h fa=%h wr=%b%b%b hidx=%h hcol=%h ha=%h end=%b",
                         r.full_index, r.full_color, r.full_alpha, r.full_color_write,
                         r.full_alpha_write, r.half_write, r.half_index, r.half_color,
                         r.half_alpha, r.frame_end);
    endfunction

    function automatic string diff_fields(input result_t want, input result_t got);
        string s;
        s = "";
        if (got.full_index !== want.full_index)             s = {s, " full_index"};
        if (got.full_color !== want.full_color)             s = {s, " full_color"};
        if (got.full_alpha !== want.full_alpha)             s = {s, " full_alpha"};
        if (got.full_color_write !== want.full_color_write) s = {s, " full_color_write"};
        if (got.full_alpha_write !== want.full_alpha_write) s = {s, " full_alpha_write"};
        if (got.half_write !== want.half_write)             s = {s, " half_write"};
        if (got.half_index !== want.half_index)             s = {s, " half_index"};
        if (got.half_color !== want.half_color)             s = {s, " half_color"};
        if (got.half_alpha !== want.half_alpha)             s = {s, " half_alpha"};
        if (got.frame_end !== want.frame_end)               s = {s, " frame_end"};
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        string   bad;
        result_t want;
        if (!rst_n)
        begin
            width_reg = 13'd64;
            height_reg = 12'd64;
            color_on = 1'b1;
            alpha_on = 1'b1;
            half_on = 1'b1;
            column = 0;
            row = 0;
            pair = '0;
            expected_words.delete();
            mismatches = 0;
        end
        else
        begin
            // result side first: a word leaving now belongs to an earlier pixel
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %s", show(result));
                end
                else
                begin
                    want = expected_words.pop_front();
                    bad = diff_fields(want, result);
                    if (bad != "")
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result word mismatch in%s", bad);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(result));
                        end
                    end
                end
            end
            if (pixel_valid && !pixel_stall)
                expected_words.push_back(convert_pixel(pixel));
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg = cfg_data;
                        column = 0;
                        row = 0;
                        pair = '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg = cfg_data[11:0];
                        column = 0;
                        row = 0;
                        pair = '0;
                    end
                    REG_FULL_COLOR_ON: color_on = cfg_data[0];
                    REG_FULL_ALPHA_ON: alpha_on = cfg_data[0];
                    REG_HALF_ON:       half_on = cfg_data[0];
                    default: ;
                endcase
            end
        end
        waiting = expected_words.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for rgba8_to_tiled_rgb565_a4: drives pixel words, register writes
// and output stalls; rgb565_tile_checker predicts and compares.
// Depends on rtr565_pkg, rgb565_tile_checker and the block itself.
module tb;
    import rtr565_pkg::*;

    typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREME} fill_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_stall;
    pixel_t                 pixel = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;

    int         mismatches;
    int         waiting;
    int         pixels_sent = 0;
    int         words_taken = 0;
    int         frame_ends = 0;
    int         half_words = 0;
    int         settings = 0;
    bit         sender_calm = 1'b0;
    reg_write_t reg_writes [$];

    pixel_t corners [24] = '{
        32'h00000000, 32'hFFFFFFFF, 32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF,
        32'h80808080, 32'h7F7F7F7F, 32'hAA55AA55, 32'h55AA55AA, 32'h08040810, 32'h0703070F,
        32'hF8FCF8F0, 32'hF7FBF7EF, 32'h01020408, 32'hFEFDFBF7, 32'h10204080, 32'h80402010,
        32'h0F1F3F7F, 32'hF0E0C080, 32'h12345678, 32'h9ABCDEF0, 32'hC3C33C3C, 32'h3C3CC3C3
    };

    int size_w [7] = '{0, 100, 128, 8191, 4096, 192, -1};
    int size_h [7] = '{0, 70, 4095, 64, 2048, 128, 64};
    int size_n [7] = '{130, 130, 260, 130, 130, 400, 150};

    rgba8_to_tiled_rgb565_a4 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    rgb565_tile_checker tile_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .waiting      (waiting)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("timed out after %0d pixels sent, %0d words taken", pixels_sent, words_taken);
        $display("status: fail");
        $finish;
    end

    // receiver: random stall after each word, calm stretches, two long hold-offs
    initial
    begin
        int stall_left;
        bit calm;
        stall_left = 0;
        calm = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                words_taken <= words_taken + 1;
                if (result.frame_end)
                    frame_ends <= frame_ends + 1;
                if (result.half_write)
                    half_words <= half_words + 1;
                if (words_taken % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                stall_left = calm ? 0 : $urandom_range(0, 5);
                if (words_taken == 700 || words_taken == 1500)
                    stall_left = 90;
            end
            result_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    function automatic pixel_t random_pixel(input fill_t fill);
        logic [7:0] c [4];
        for (int k = 0; k < 4; k++)
        begin
            case (fill)
                FILL_WHITE:   c[k] = 8'hFF;
                FILL_BLACK:   c[k] = 8'h00;
                FILL_EXTREME: c[k] = ($urandom_range(0, 2) == 0) ? 8'h00 :
                                     ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom);
                default:      c[k] = 8'($urandom);
            endcase
        end
        return {c[0], c[1], c[2], c[3]};
    endfunction

    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= p;
        do @(posedge clk); while (pixel_stall);
        pixels_sent++;
        if (pixels_sent % 40 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_run(input int count);
        fill_t fill;
        fill = FILL_RANDOM;
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       fill = FILL_WHITE;
                    1:       fill = FILL_BLACK;
                    2, 3, 4: fill = FILL_EXTREME;
                    default: fill = FILL_RANDOM;
                endcase
            end
            send_pixel(random_pixel(fill));
        end
    endtask

    // drop valid and wait until every word sent has come back
    task automatic settle();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (words_taken != pixels_sent);
    endtask

    task automatic queue_write(input logic [CFG_INDEX_W-1:0] index, input int value);
        reg_writes.push_back('{index: index, data: CFG_DATA_W'(value)});
    endtask

    task automatic apply_writes();
        reg_write_t cur;
        if (reg_writes.size() > 0)
            settings++;
        while (reg_writes.size() > 0)
        begin
            cur = reg_writes.pop_front();
            cfg_write <= 1'b1;
            cfg_index <= cur.index;
            cfg_data <= cur.data;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int left;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // corner values on the first row of the reset 64x64 frame
        foreach (corners[i])
            send_pixel(corners[i]);

        // several more rows of that frame, toggling the enables on the way
        left = 600 - $size(corners);
        while (left > 0)
        begin
            n = $urandom_range(150, 600);
            if (n > left)
                n = left;
            settle();
            if ($urandom_range(0, 1) == 1)
                queue_write(REG_FULL_COLOR_ON, $urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
                queue_write(REG_FULL_ALPHA_ON, $urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
                queue_write(REG_HALF_ON, $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                queue_write(CFG_INDEX_W'(REG_HALF_ON + $urandom_range(1, 3)), $urandom);
            apply_writes();
            send_run(n);
            left -= n;
        end

        // image sizes: zero, unaligned, tall, wide, maximal, and a height-only restart
        foreach (size_n[i])
        begin
            settle();
            if (size_w[i] >= 0)
                queue_write(REG_IMAGE_WIDTH, size_w[i]);
            queue_write(REG_IMAGE_HEIGHT, size_h[i]);
            queue_write(REG_FULL_COLOR_ON, (i == 1) ? 0 : (i == 0) ? 1 : $urandom_range(0, 1));
            queue_write(REG_FULL_ALPHA_ON, (i == 1) ? 0 : (i == 0) ? 1 : $urandom_range(0, 1));
            queue_write(REG_HALF_ON, (i == 1) ? 0 : (i == 0 || i == 2) ? 1 : $urandom_range(0, 1));
            apply_writes();
            send_run(size_n[i]);
        end

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d pixels over %0d register settings: %0d half-size words, %0d frame ends",
                 pixels_sent, settings, half_words, frame_ends);
        if (mismatches == 0 && waiting == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatching words, %0d predicted words never seen", mismatches, waiting);
            $display("status: fail");
        end
        $finish;
    end

endmodule
